[src/ber_tag_length_header_parser_assert.svh]
// Assertion macros for the BER tag and length header parser.
`ifndef BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH
`define BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define BTLH_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("btlh: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define BTLH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btlh: implication violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define BTLH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btlh: next-cycle implication violated");

`else

`define BTLH_ASSERT_ALWAYS(label, clk, rst, expr)
`define BTLH_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BTLH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/btlh_pkg.sv]
// Shared types and constants of the BER tag and length header parser.
package btlh_pkg;

   // Longest supported long-form length, in bytes.
   localparam int unsigned MAX_LENGTH_BYTES = 4;

   // Configuration register indexes.
   localparam logic CSR_BUDGET_LENGTH     = 1'b0;
   localparam logic CSR_BUDGET_INDEFINITE = 1'b1;

   // Byte values that steer the decode.
   localparam logic [4:0] TAG_LONG_FORM   = 5'h1f;
   localparam logic [7:0] LEN_INDEFINITE  = 8'h80;

   typedef enum logic [1:0] {
      PH_TAG_FIRST,
      PH_TAG_EXT,
      PH_LEN_FIRST,
      PH_LEN_MORE
   } btlh_phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NODATA,
      ST_UNSUPP,
      ST_FAULT
   } btlh_status_type;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      btlh_phase_type phase;
      logic [31:0]    tag_acc;
      logic [1:0]     tag_idx;
      logic [31:0]    len_acc;
      logic [2:0]     len_left;
      logic [31:0]    budget_left;
   } btlh_state_type;

   // One decoded header or error report.
   typedef struct packed {
      logic [31:0]     tag_word;
      logic [31:0]     length_value;
      logic            length_indefinite;
      btlh_status_type status;
   } btlh_result_type;

endpackage

[src/ber_tag_length_header_parser.sv]
// Top level of the BER tag and length header parser.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    data_byte, source_fault
//   rsp      out        rsp_valid/stall    tag_word, length_value, length_indefinite, status
//   csr      in         csr_write_enable   csr_index, csr_write_data
//
// One byte is decoded per cycle while the result is not stalled: a transaction lands in the
// input register, and when it advances the decode logic updates the parser state and loads
// the result register, from which a result is offered once its last byte is decoded.
// Synchronous reset clears the parser, sets the budget to zero and marks it indefinite.
// A stalled result blocks decode only while a byte waits in the input register.
module ber_tag_length_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_source_fault,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_tag_word,
   output logic [31:0] rsp_length_value,
   output logic        rsp_length_indefinite,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

`include "ber_tag_length_header_parser_assert.svh"

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_fault_ff;
   logic                      out_valid_ff, out_valid_in;
   btlh_pkg::btlh_result_type out_ff;
   btlh_pkg::btlh_state_type  state_ff, state_in;
   logic                      budget_indef_ff;
   btlh_pkg::btlh_state_type  dec_state;
   logic                      dec_valid;
   btlh_pkg::btlh_result_type dec_result;
   logic                      req_accept;
   logic                      advance;

   // Handshake control.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   btlh_decode u_decode (
      .state             (state_ff),
      .budget_indefinite (budget_indef_ff),
      .data_byte         (in_byte_ff),
      .source_fault      (in_fault_ff),
      .next_state        (dec_state),
      .result_valid      (dec_valid),
      .result            (dec_result)
   );

   // Next values of the valid flags and the parser state.
   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      out_valid_in = (advance && dec_valid) || (out_valid_ff && rsp_stall);
      state_in     = advance ? dec_state : state_ff;
      if (csr_write_enable && (csr_index == btlh_pkg::CSR_BUDGET_LENGTH)) begin
         state_in.budget_left = csr_write_data;
      end
   end

   // Control and parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         state_ff        <= '0;
         budget_indef_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         if (csr_write_enable && (csr_index == btlh_pkg::CSR_BUDGET_INDEFINITE)) begin
            budget_indef_ff <= csr_write_data[0];
         end
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_data_byte;
         in_fault_ff <= req_source_fault;
      end
      if (advance && dec_valid) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_tag_word          = out_ff.tag_word;
   assign rsp_length_value      = out_ff.length_value;
   assign rsp_length_indefinite = out_ff.length_indefinite;
   assign rsp_status            = out_ff.status;

   // An error report never carries header fields.
   `BTLH_ASSERT_IMPLIES(a_error_fields_zero, clock, reset,
      out_valid_ff && (out_ff.status != btlh_pkg::ST_OK),
      (out_ff.tag_word == 32'd0) && (out_ff.length_value == 32'd0) && !out_ff.length_indefinite)

   // An indefinite length reports a zero length value.
   `BTLH_ASSERT_IMPLIES(a_indef_len_zero, clock, reset,
      out_valid_ff && out_ff.length_indefinite, out_ff.length_value == 32'd0)

   // While gathering long-form length bytes, one to four remain.
   `BTLH_ASSERT_ALWAYS(a_len_left_range, clock, reset,
      (state_ff.phase != btlh_pkg::PH_LEN_MORE) ||
      ((state_ff.len_left != 3'd0) && (state_ff.len_left <= 3'd4)))

   // An indefinite budget is never charged by a decoded byte.
   `BTLH_ASSERT_NEXT(a_indef_budget_stable, clock, reset,
      advance && budget_indef_ff && !csr_write_enable, $stable(state_ff.budget_left))

endmodule

[src/btlh_decode.sv]
// Combinational decode of one byte against the current parser state.
module btlh_decode (
   input  btlh_pkg::btlh_state_type  state,
   input  logic                      budget_indefinite,
   input  logic [7:0]                data_byte,
   input  logic                      source_fault,
   output btlh_pkg::btlh_state_type  next_state,
   output logic                      result_valid,
   output btlh_pkg::btlh_result_type result
);

   logic       no_data;
   logic       tag_long;
   logic [1:0] ext_idx;
   logic       ext_more;
   logic       len_long;
   logic       len_indef;
   logic       len_too_long;
   logic [2:0] len_left_dec;
   logic [31:0] ext_bits;
   btlh_pkg::btlh_phase_type next_phase;

   // Common conditions of the current byte.
   always_comb begin
      no_data      = !budget_indefinite && (state.budget_left == 32'd0);
      tag_long     = (data_byte[4:0] == btlh_pkg::TAG_LONG_FORM);
      ext_idx      = (state.tag_idx == 2'd0) ? 2'd1 : state.tag_idx;
      ext_more     = data_byte[7];
      len_long     = data_byte[7];
      len_indef    = (data_byte == btlh_pkg::LEN_INDEFINITE);
      len_too_long = (data_byte[6:0] > 7'(btlh_pkg::MAX_LENGTH_BYTES));
      len_left_dec = (state.len_left != 3'd0) ? (state.len_left - 3'd1) : 3'd0;
      ext_bits     = {24'd0, data_byte} << {ext_idx, 3'b000};
   end

   // Next phase.
   always_comb begin
      next_phase = state.phase;
      if (no_data || source_fault) begin
         next_phase = btlh_pkg::PH_TAG_FIRST;
      end else begin
         unique case (state.phase)
            btlh_pkg::PH_TAG_FIRST: begin
               next_phase = tag_long ? btlh_pkg::PH_TAG_EXT : btlh_pkg::PH_LEN_FIRST;
            end
            btlh_pkg::PH_TAG_EXT: begin
               if (!ext_more) begin
                  next_phase = btlh_pkg::PH_LEN_FIRST;
               end else if (ext_idx == 2'd3) begin
                  next_phase = btlh_pkg::PH_TAG_FIRST;
               end
            end
            btlh_pkg::PH_LEN_FIRST: begin
               if (len_long && !len_indef && !len_too_long) begin
                  next_phase = btlh_pkg::PH_LEN_MORE;
               end else begin
                  next_phase = btlh_pkg::PH_TAG_FIRST;
               end
            end
            btlh_pkg::PH_LEN_MORE: begin
               if (len_left_dec == 3'd0) begin
                  next_phase = btlh_pkg::PH_TAG_FIRST;
               end
            end
            default: next_phase = btlh_pkg::PH_TAG_FIRST;
         endcase
      end
   end

   // Accumulators, budget and the result.
   always_comb begin
      next_state.phase       = next_phase;
      next_state.tag_acc     = state.tag_acc;
      next_state.tag_idx     = state.tag_idx;
      next_state.len_acc     = state.len_acc;
      next_state.len_left    = state.len_left;
      next_state.budget_left = state.budget_left;
      result_valid           = 1'b0;
      result                 = '0;
      result.status          = btlh_pkg::ST_OK;

      if (no_data) begin
         result_valid  = 1'b1;
         result.status = btlh_pkg::ST_NODATA;
      end else if (source_fault) begin
         result_valid  = 1'b1;
         result.status = btlh_pkg::ST_FAULT;
      end else begin
         if (!budget_indefinite) begin
            next_state.budget_left = state.budget_left - 32'd1;
         end
         unique case (state.phase)
            btlh_pkg::PH_TAG_FIRST: begin
               next_state.tag_acc = {24'd0, data_byte};
               if (tag_long) begin
                  next_state.tag_idx = 2'd1;
               end
            end
            btlh_pkg::PH_TAG_EXT: begin
               next_state.tag_acc = state.tag_acc | ext_bits;
               if (ext_more) begin
                  if (ext_idx == 2'd3) begin
                     result_valid  = 1'b1;
                     result.status = btlh_pkg::ST_UNSUPP;
                  end else begin
                     next_state.tag_idx = ext_idx + 2'd1;
                  end
               end
            end
            btlh_pkg::PH_LEN_FIRST: begin
               if (!len_long) begin
                  result_valid        = 1'b1;
                  result.tag_word     = state.tag_acc;
                  result.length_value = {24'd0, data_byte};
               end else if (len_indef) begin
                  result_valid             = 1'b1;
                  result.tag_word          = state.tag_acc;
                  result.length_indefinite = 1'b1;
               end else if (len_too_long) begin
                  result_valid  = 1'b1;
                  result.status = btlh_pkg::ST_UNSUPP;
               end else begin
                  next_state.len_acc  = 32'd0;
                  next_state.len_left = data_byte[2:0];
               end
            end
            btlh_pkg::PH_LEN_MORE: begin
               next_state.len_acc  = {state.len_acc[23:0], data_byte};
               next_state.len_left = len_left_dec;
               if (len_left_dec == 3'd0) begin
                  result_valid        = 1'b1;
                  result.tag_word     = state.tag_acc;
                  result.length_value = {state.len_acc[23:0], data_byte};
               end
            end
            default: result = '0;
         endcase
      end

      // Every result starts a new header.
      if (result_valid) begin
         next_state.tag_acc  = 32'd0;
         next_state.tag_idx  = 2'd0;
         next_state.len_acc  = 32'd0;
         next_state.len_left = 3'd0;
      end
   end

endmodule
